// ===== src/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

// ===== src/pcf_pkg.sv =====
package pcf_pkg;

    localparam int FRAC_W        = 10;
    localparam int STEP_W        = 10;
    localparam int IDX_W         = 3;
    localparam int MODE_W        = 2;
    localparam int MODE_COUNT    = 3;
    localparam int CH_W          = 8;
    localparam int LAMP_COUNT    = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 10;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = LAMP_COUNT * 3 * CH_W;
    localparam int FRAC_HALF     = 1 << (FRAC_W - 1);
    localparam int STEP_RESET    = 2;

    localparam logic [MODE_W-1:0] MODE_RAINBOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WARM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COOL    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PALETTE_MODE   = 1'b0,
        CFG_STEP_INCREMENT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb              lo;
        t_rgb              hi;
        logic [FRAC_W-1:0] frac;
    } t_lamp_src;

    function automatic logic [MODE_W-1:0] active_mode(input logic [MODE_W-1:0] mode);
        return (int'(mode) < MODE_COUNT) ? mode : MODE_RAINBOW;
    endfunction

    function automatic logic [IDX_W:0] palette_len(input logic [MODE_W-1:0] mode);
        return (mode == MODE_RAINBOW) ? 4'd6 : 4'd4;
    endfunction

    // v < 2*n holds for every caller
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] v,
                                                  input logic [IDX_W:0] n);
        logic [IDX_W:0] d;
        d = v - n;
        return (v >= n) ? d[IDX_W-1:0] : v[IDX_W-1:0];
    endfunction

    function automatic t_rgb rgb(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                 input logic [CH_W-1:0] b);
        t_rgb c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    function automatic t_rgb palette_color(input logic [MODE_W-1:0] mode,
                                           input logic [IDX_W-1:0] idx);
        t_rgb c;
        c = rgb(8'd0, 8'd0, 8'd0);
        case (mode)
            MODE_RAINBOW: begin
                case (idx)
                    3'd0:    c = rgb(8'd0,   8'd255, 8'd0);
                    3'd1:    c = rgb(8'd0,   8'd128, 8'd128);
                    3'd2:    c = rgb(8'd0,   8'd0,   8'd255);
                    3'd3:    c = rgb(8'd128, 8'd0,   8'd128);
                    3'd4:    c = rgb(8'd255, 8'd0,   8'd0);
                    3'd5:    c = rgb(8'd128, 8'd128, 8'd0);
                    default: c = rgb(8'd0,   8'd0,   8'd0);
                endcase
            end
            MODE_WARM: begin
                case (idx)
                    3'd0:    c = rgb(8'd255, 8'd0,   8'd0);
                    3'd1:    c = rgb(8'd128, 8'd128, 8'd0);
                    3'd2:    c = rgb(8'd208, 8'd48,  8'd0);
                    3'd3:    c = rgb(8'd138, 8'd118, 8'd0);
                    default: c = rgb(8'd0,   8'd0,   8'd0);
                endcase
            end
            MODE_COOL: begin
                case (idx)
                    3'd0:    c = rgb(8'd0,   8'd0,   8'd255);
                    3'd1:    c = rgb(8'd0,   8'd128, 8'd128);
                    3'd2:    c = rgb(8'd10,  8'd30,  8'd215);
                    3'd3:    c = rgb(8'd0,   8'd148, 8'd108);
                    default: c = rgb(8'd0,   8'd0,   8'd0);
                endcase
            end
            default: c = rgb(8'd0, 8'd0, 8'd0);
        endcase
        return c;
    endfunction

endpackage

// ===== src/pcf_position.sv =====
module pcf_position (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic                                          i_advance,
    input  logic [pcf_pkg::MODE_W-1:0]                    i_mode,
    input  logic [pcf_pkg::STEP_W-1:0]                    i_step,
    output pcf_pkg::t_lamp_src [pcf_pkg::LAMP_COUNT-1:0]  o_lamp
);
    import pcf_pkg::*;

    logic [IDX_W-1:0]   r_seg_index;
    logic [FRAC_W-1:0]  r_seg_frac;
    logic [IDX_W-1:0]   n_seg_index;
    logic [FRAC_W-1:0]  n_seg_frac;
    t_lamp_src [LAMP_COUNT-1:0] r_lamp;
    t_lamp_src [LAMP_COUNT-1:0] n_lamp;

    logic [MODE_W-1:0]  mode;
    logic [IDX_W:0]     len;
    logic [IDX_W-1:0]   idx;
    logic [FRAC_W:0]    frac_b;
    logic [FRAC_W:0]    step_sum;
    logic [IDX_W-1:0]   lo_a, lo_b, lo_c;

    always_comb begin
        mode     = active_mode(i_mode);
        len      = palette_len(mode);
        idx      = wrap_idx({1'b0, r_seg_index}, len);
        frac_b   = {1'b0, r_seg_frac} + (FRAC_W + 1)'(FRAC_HALF);
        step_sum = {1'b0, r_seg_frac} + {1'b0, i_step};

        lo_a = idx;
        lo_b = wrap_idx({1'b0, idx} + (IDX_W + 1)'(frac_b[FRAC_W]), len);
        lo_c = wrap_idx({1'b0, idx} + (IDX_W + 1)'(1), len);

        n_lamp[0].lo   = palette_color(mode, lo_a);
        n_lamp[0].hi   = palette_color(mode, wrap_idx({1'b0, lo_a} + (IDX_W + 1)'(1), len));
        n_lamp[0].frac = r_seg_frac;
        n_lamp[1].lo   = palette_color(mode, lo_b);
        n_lamp[1].hi   = palette_color(mode, wrap_idx({1'b0, lo_b} + (IDX_W + 1)'(1), len));
        n_lamp[1].frac = frac_b[FRAC_W-1:0];
        n_lamp[2].lo   = palette_color(mode, lo_c);
        n_lamp[2].hi   = palette_color(mode, wrap_idx({1'b0, lo_c} + (IDX_W + 1)'(1), len));
        n_lamp[2].frac = r_seg_frac;

        n_seg_index = wrap_idx({1'b0, idx} + (IDX_W + 1)'(step_sum[FRAC_W]), len);
        n_seg_frac  = step_sum[FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_index <= '0;
            r_seg_frac  <= '0;
        end else if (i_load && i_advance) begin
            r_seg_index <= n_seg_index;
            r_seg_frac  <= n_seg_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lamp <= n_lamp;
        end
    end

    assign o_lamp = r_lamp;

endmodule

// ===== src/pcf_mix.sv =====
module pcf_mix (
    input  pcf_pkg::t_lamp_src i_src,
    output pcf_pkg::t_rgb      o_color
);
    import pcf_pkg::*;

    localparam int ACC_W = CH_W + FRAC_W + 2;

    logic [2:0][CH_W-1:0]      lo_ch;
    logic [2:0][CH_W-1:0]      hi_ch;
    logic [2:0][CH_W-1:0]      mix_ch;
    logic signed [CH_W:0]      diff [3];
    logic signed [ACC_W-1:0]   prod [3];
    logic signed [ACC_W-1:0]   acc  [3];

    // lo*(1-f) + hi*f == lo + (hi-lo)*f, rounded half up
    always_comb begin
        lo_ch = i_src.lo;
        hi_ch = i_src.hi;
        for (int k = 0; k < 3; k++) begin
            diff[k]   = $signed({1'b0, hi_ch[k]}) - $signed({1'b0, lo_ch[k]});
            prod[k]   = ACC_W'(diff[k]) * ACC_W'($signed({1'b0, i_src.frac}));
            acc[k]    = $signed({2'b00, lo_ch[k], FRAC_W'(0)}) + prod[k]
                        + $signed(ACC_W'(FRAC_HALF));
            mix_ch[k] = acc[k][FRAC_W +: CH_W];
        end
    end

    assign o_color = mix_ch;

endmodule

// ===== src/palette_color_fader_core.sv =====
// Three-lamp palette color fader.
// Slave stream: one transfer per tick, tdata[0] = advance (1: emit then move the
// position by step_increment, 0: emit only). Master stream: one transfer per
// tick carrying lamps A, B and C as 8-bit RGB, lamp A red in the lowest byte.
// Config channel: index 0 = palette_mode, index 1 = step_increment; it is
// always ready and must only be written while no tick is in flight.
// Each result passes through the palette lookup register, then the blend and
// output register. Throughput: one tick per cycle while the receiver keeps up;
// the two stages form a pipeline whose per-cycle limit is the nine 9x10 blend
// multipliers in front of the output.
// Reset: palette_mode 0, step_increment 2, position 0, both stages empty.
// When the receiver stalls, the output holds its transfer, one more tick is
// taken into the lookup stage, and then o_s_axis_tready drops.
module palette_color_fader_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [pcf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [0] advance, [7:1] zero
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // from bit 0 up: lamp_a_red, lamp_a_green, lamp_a_blue, lamp_b_red,
    // lamp_b_green, lamp_b_blue, lamp_c_red, lamp_c_green, lamp_c_blue
    output logic [pcf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pcf_pkg::*;

    logic [MODE_W-1:0]          r_mode;
    logic [STEP_W-1:0]          r_step;
    logic                       r_s1_valid;
    logic                       n_s1_valid;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [OUT_TDATA_W-1:0]     r_out_data;
    logic [OUT_TDATA_W-1:0]     n_out_data;

    logic                       in_xfer;
    logic                       out_ready;
    logic                       out_load;
    t_lamp_src [LAMP_COUNT-1:0] lamp_src;
    t_rgb      [LAMP_COUNT-1:0] lamp_color;

    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || out_ready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = r_s1_valid && out_ready;
    assign o_cfg_ready     = 1'b1;

    pcf_position u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_xfer),
        .i_advance (i_s_axis_tdata[0]),
        .i_mode    (r_mode),
        .i_step    (r_step),
        .o_lamp    (lamp_src)
    );

    for (genvar g = 0; g < LAMP_COUNT; g++) begin : g_lamp
        pcf_mix u_mix (
            .i_src   (lamp_src[g]),
            .o_color (lamp_color[g])
        );
    end

    always_comb begin
        n_s1_valid  = in_xfer || (r_s1_valid && !out_ready);
        n_out_valid = out_load || (r_out_valid && !i_m_axis_tready);
        for (int k = 0; k < LAMP_COUNT; k++) begin
            n_out_data[k*3*CH_W +: 3*CH_W] =
                {lamp_color[k].blue, lamp_color[k].green, lamp_color[k].red};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RAINBOW;
            r_step      <= STEP_W'(STEP_RESET);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_PALETTE_MODE:   r_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_STEP_INCREMENT: r_step <= i_cfg_data[STEP_W-1:0];
                    default:            r_mode <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== src/pcf_checker.sv =====
`include "assert_macros.svh"

module pcf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [pcf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [pcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [pcf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pcf_pkg::*;

    logic in_xfer;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // output register comes out of reset empty
    `ASSERT_ALWAYS(a_empty_after_reset, $past(!i_rst_n) |-> !o_m_axis_tvalid)

    // a stalled result holds
    `ASSERT_CLK(a_hold_on_stall,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // a result appearing on an idle output came in via the lookup and output registers
    `ASSERT_CLK(a_two_cycle_latency, $rose(o_m_axis_tvalid) |-> $past(in_xfer, 2))

    // with the output empty the lookup stage always drains, so input is open
    `ASSERT_CLK(a_ready_when_drained, !o_m_axis_tvalid |-> o_s_axis_tready)

    // register writes must land only while no transfer is pending; core does not enforce it
    `ASSERT_CLK(a_cfg_when_idle, i_cfg_valid && o_cfg_ready |-> !o_m_axis_tvalid
        && !i_s_axis_tvalid && !$isunknown({i_cfg_index, i_cfg_data}))

endmodule

bind palette_color_fader_core pcf_checker u_pcf_checker (.*);

// ===== dv/palette_color_fader_core_tb.sv =====
module palette_color_fader_core_tb;
    import pcf_pkg::*;

    localparam int                CYCLE_LIMIT  = 300000;
    localparam int                RANDOM_TICKS = 62;
    localparam int                PHASE_COUNT  = 12;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    typedef struct {
        bit                      is_write;
        t_cfg_reg                reg_sel;
        logic [CFG_DATA_W-1:0]   value;
        bit                      adv;
        bit                      typed;
        logic [OUT_TDATA_W-1:0]  colors;
    } t_plan_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // entries are {blue, green, red}, red in the low byte like the output lamps
    logic [23:0] fader_rom [0:2][0:5] = '{
        '{{8'd0, 8'd255, 8'd0}, {8'd128, 8'd128, 8'd0}, {8'd255, 8'd0, 8'd0},
          {8'd128, 8'd0, 8'd128}, {8'd0, 8'd0, 8'd255}, {8'd0, 8'd128, 8'd128}},
        '{{8'd0, 8'd0, 8'd255}, {8'd0, 8'd128, 8'd128}, {8'd0, 8'd48, 8'd208},
          {8'd0, 8'd118, 8'd138}, 24'd0, 24'd0},
        '{{8'd255, 8'd0, 8'd0}, {8'd128, 8'd128, 8'd0}, {8'd215, 8'd30, 8'd10},
          {8'd108, 8'd148, 8'd0}, 24'd0, 24'd0}
    };

    string lamp_fields [0:8] = '{"lamp_a_red", "lamp_a_green", "lamp_a_blue",
                                 "lamp_b_red", "lamp_b_green", "lamp_b_blue",
                                 "lamp_c_red", "lamp_c_green", "lamp_c_blue"};

    logic [OUT_TDATA_W-1:0] lamp_colors_due [$];
    t_plan_row              directed_plan [$];

    int                     fail_count = 0;
    int                     cycle_count = 0;
    int                     sender_idle_pct = 0;
    int                     receiver_stall_pct = 0;

    logic [MODE_W-1:0]      fader_mode = MODE_RAINBOW;
    int                     fader_step = STEP_RESET;
    int                     fader_index = 0;
    int                     fader_frac = 0;

    palette_color_fader_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic [23:0] blend_entry(int pal, int len, int pos, int frac);
        logic [23:0] lo;
        logic [23:0] hi;
        logic [23:0] mixed;
        int          lo_i;
        int          ch;
        lo_i = pos % len;
        lo   = fader_rom[pal][lo_i];
        hi   = fader_rom[pal][(lo_i + 1) % len];
        for (int k = 0; k < 3; k++) begin
            ch = (int'(lo[8*k +: 8]) * (1024 - frac) + int'(hi[8*k +: 8]) * frac + 512) >> 10;
            mixed[8*k +: 8] = ch[7:0];
        end
        return mixed;
    endfunction

    // colors for the current position, then the position moves on if advance is set
    function automatic logic [OUT_TDATA_W-1:0] fade_tick(bit adv);
        logic [OUT_TDATA_W-1:0] lamps;
        int                     pal;
        int                     len;
        int                     pos;
        int                     half;
        int                     sum;
        pal  = (int'(fader_mode) < MODE_COUNT) ? int'(fader_mode) : 0;
        len  = (pal == 0) ? 6 : 4;
        pos  = fader_index % len;
        half = fader_frac + FRAC_HALF;
        lamps[23:0]  = blend_entry(pal, len, pos, fader_frac);
        lamps[47:24] = blend_entry(pal, len, pos + (half >> FRAC_W), half & 1023);
        lamps[71:48] = blend_entry(pal, len, pos + 1, fader_frac);
        if (adv) begin
            sum         = fader_frac + fader_step;
            fader_index = (pos + (sum >> FRAC_W)) % len;
            fader_frac  = sum & 1023;
        end
        return lamps;
    endfunction

    function automatic void plan_tick(bit adv, bit typed, logic [OUT_TDATA_W-1:0] colors);
        t_plan_row row;
        row.is_write = 1'b0;
        row.reg_sel  = CFG_PALETTE_MODE;
        row.value    = '0;
        row.adv      = adv;
        row.typed    = typed;
        row.colors   = colors;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_write(t_cfg_reg sel, logic [CFG_DATA_W-1:0] value);
        t_plan_row row;
        row.is_write = 1'b1;
        row.reg_sel  = sel;
        row.value    = value;
        row.adv      = 1'b0;
        row.typed    = 1'b0;
        row.colors   = '0;
        directed_plan.push_back(row);
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_TDATA_W-1:0] due;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (lamp_colors_due.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                due = lamp_colors_due.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (m_tdata[8*k +: 8] !== due[8*k +: 8]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, lamp_fields[k],
                                 due[8*k +: 8], m_tdata[8*k +: 8]);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (lamp_colors_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg sel, logic [CFG_DATA_W-1:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (sel == CFG_PALETTE_MODE) fader_mode = value[MODE_W-1:0];
        else fader_step = int'(value);
    endtask

    task automatic send_tick(bit adv, bit typed, logic [OUT_TDATA_W-1:0] colors);
        logic [OUT_TDATA_W-1:0] predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, adv};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predicted = fade_tick(adv);
        lamp_colors_due.push_back(typed ? colors : predicted);
    endtask

    task automatic set_traffic(int profile);
        case (profile)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
            default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
        endcase
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] step_val;
        // position 0 of the rainbow palette: A on entry 0, B halfway, C on entry 1
        plan_tick(1'b0, 1'b1, {8'd128, 8'd128, 8'd0, 8'd64, 8'd192, 8'd0, 8'd0, 8'd255, 8'd0});
        plan_tick(1'b1, 1'b1, {8'd128, 8'd128, 8'd0, 8'd64, 8'd192, 8'd0, 8'd0, 8'd255, 8'd0});
        plan_tick(1'b1, 1'b0, '0);
        plan_write(CFG_STEP_INCREMENT, 10'd1023);
        repeat (4) plan_tick(1'b1, 1'b0, '0);
        plan_write(CFG_STEP_INCREMENT, 10'd0);
        plan_tick(1'b1, 1'b0, '0);
        plan_tick(1'b0, 1'b0, '0);
        plan_write(CFG_STEP_INCREMENT, 10'd512);
        repeat (3) plan_tick(1'b1, 1'b0, '0);
        // index sits past the end of the shorter palettes here
        plan_write(CFG_PALETTE_MODE, {8'd0, MODE_WARM});
        plan_tick(1'b0, 1'b0, '0);
        plan_tick(1'b1, 1'b0, '0);
        plan_tick(1'b1, 1'b0, '0);
        plan_write(CFG_PALETTE_MODE, {8'd0, MODE_COOL});
        plan_tick(1'b1, 1'b0, '0);
        plan_tick(1'b1, 1'b0, '0);
        plan_write(CFG_PALETTE_MODE, {8'd0, MODE_UNUSED});
        plan_tick(1'b1, 1'b0, '0);
        plan_tick(1'b0, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_traffic(0);
        foreach (directed_plan[r]) begin
            if (directed_plan[r].is_write)
                write_register(directed_plan[r].reg_sel, directed_plan[r].value);
            else
                send_tick(directed_plan[r].adv, directed_plan[r].typed, directed_plan[r].colors);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph % 6)
                0: step_val = 10'd1023;
                1: step_val = 10'($urandom_range(1, 15));
                2: step_val = 10'($urandom_range(1023));
                3: step_val = 10'd0;
                4: step_val = 10'($urandom_range(256, 767));
                default: step_val = 10'($urandom_range(1023));
            endcase
            write_register(CFG_PALETTE_MODE, {8'd0, 2'(ph % 4)});
            write_register(CFG_STEP_INCREMENT, step_val);
            set_traffic((ph + ph / 4) % 4);
            for (int n = 0; n < RANDOM_TICKS; n++) begin
                if (ph == 5 && n == 30) drain_pipeline();
                send_tick($urandom_range(3) != 0, 1'b0, '0);
            end
        end

        drain_pipeline();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && lamp_colors_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
